FILE: src/asob_pkg.sv
// Shared constants and types for the additive sine oscillator bank.
package asob_pkg;

	localparam int NUM_PARTIALS_DEF = 60;
	localparam int PHASE_BITS_DEF   = 24;
	localparam int SINE_DEPTH_DEF   = 1024;

	// Amplitude reset of 0.8 in Q0.16, applied every AMP_PERIOD partials
	localparam logic [15:0] AMP_RESET  = 16'd52429;
	localparam int          AMP_PERIOD = 12;
	// Output gain reset of 0.2 in Q0.16
	localparam logic [15:0] GAIN_RESET = 16'd13107;

	// pi in Q2.30
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_AMP  = 2'd1,
		KIND_INC  = 2'd2
	} kind_t;

endpackage

FILE: src/asob_sine_rom.sv
// Quarter-wave sine table with quadrant folding and a registered read.
module asob_sine_rom import asob_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] idx,
	input  logic                                fold,
	output logic [15:0]                         mag_s3
);

	localparam int SW = $clog2(SINE_TABLE_DEPTH);

	typedef logic [15:0] rom_t [SINE_TABLE_DEPTH];

	// Entry k = sin(pi/2 * (k + 0.5) / depth), Taylor series to x^13 in Q2.30
	function automatic rom_t build_rom();
		rom_t               rom;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        r;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			x    = (PI_Q30 * 64'(2 * k + 1)) / 64'(4 * SINE_TABLE_DEPTH);
			x2   = (x * x) >> 30;
			term = x;
			sum  = $signed(x);
			term = ((term * x2) >> 30) / 64'd6;
			sum  = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd20;
			sum  = sum + $signed(term);
			term = ((term * x2) >> 30) / 64'd42;
			sum  = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd72;
			sum  = sum + $signed(term);
			term = ((term * x2) >> 30) / 64'd110;
			sum  = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd156;
			sum  = sum + $signed(term);
			if (sum < 0) begin
				sum = '0;
			end
			r = ($unsigned(sum) + 64'd8192) >> 14;
			if (r > 64'd65535) begin
				r = 64'd65535;
			end
			rom[k] = r[15:0];
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic [SW-1:0] addr;

	// Mirror the index in quadrants 1 and 3
	assign addr = fold ? (SW'(SINE_TABLE_DEPTH - 1) - idx) : idx;

	always_ff @(posedge clk) begin
		mag_s3 <= SINE_ROM[addr];
	end

endmodule

FILE: src/additive_sine_oscillator_bank.sv
// Additive sine oscillator bank: partial state memories, tick walk and output mixing.
// A tick walks all partials, drains the pipeline, scales and saturates the sum; the next
// item can be taken in the same cycle as the sample appears. One partial enters per cycle
// through the read ports of the partial memories. A write reads the entry, merges the new
// field and writes it back. Reset clears control state, the gain to 13107 and the entry
// valid bits; an entry reads its reset value until written, so no clearing pass runs.
module additive_sine_oscillator_bank import asob_pkg::*; #(
	parameter int NUM_PARTIALS     = NUM_PARTIALS_DEF,
	parameter int PHASE_BITS       = PHASE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
	localparam int AW = (NUM_PARTIALS > 1) ? $clog2(NUM_PARTIALS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [AW-1:0]      partial_index,
	input  logic [23:0]        write_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] sample_out
);

	localparam int RW    = PHASE_BITS - 2;
	localparam int SW    = $clog2(SINE_TABLE_DEPTH);
	localparam int DW    = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PW    = RW + DW;
	localparam int ACC_W = 33 + $clog2(NUM_PARTIALS + 1);
	localparam int PRW   = ACC_W + 17;
	localparam int SHW   = PRW - 24;
	localparam int EXW   = (SHW > 32) ? SHW : 33;
	localparam logic [AW-1:0] LAST = AW'(NUM_PARTIALS - 1);

	function automatic logic [NUM_PARTIALS-1:0] amp_on_mask();
		logic [NUM_PARTIALS-1:0] m;
		for (int i = 0; i < NUM_PARTIALS; i++) begin
			m[i] = ((i % AMP_PERIOD) == 0);
		end
		return m;
	endfunction

	localparam logic [NUM_PARTIALS-1:0] AMP_ON = amp_on_mask();

	typedef struct packed {
		logic [15:0]           amp;
		logic [PHASE_BITS-1:0] inc;
	} par_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_WR_RD,
		ST_WR_WB,
		ST_DRAIN,
		ST_SCALE,
		ST_SAT
	} state_t;

	state_t state_q;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] widx_q;
	logic [23:0]   wval_q;
	logic          wamp_q;
	logic [15:0]   gain_q;
	logic          out_valid_q;
	logic signed [31:0] sample_q;

	par_t                  par_mem [NUM_PARTIALS];
	logic [PHASE_BITS-1:0] ph_mem  [NUM_PARTIALS];
	logic [NUM_PARTIALS-1:0] par_vld_q;
	logic [NUM_PARTIALS-1:0] ph_vld_q;

	logic [AW-1:0]         rd_addr;
	par_t                  par_rd_s1;
	logic [PHASE_BITS-1:0] ph_rd_s1;
	logic                  par_vld_s1;
	logic                  ph_vld_s1;
	logic [AW-1:0]         j_s1;
	logic                  go_s1, go_s2, go_s3, go_s4;

	logic [15:0]           amp_s1c;
	logic [PHASE_BITS-1:0] inc_s1c;
	logic [PHASE_BITS-1:0] ph_s1c;
	logic [PHASE_BITS-1:0] ph_next;
	logic [31:0]           sq_s1c;
	logic [PW-1:0]         scaled_s1c;
	logic                  par_we;
	par_t                  par_wd;

	logic [15:0]   a2_s2;
	logic [SW-1:0] idx_s2;
	logic [1:0]    quad_s2;
	logic [15:0]   a2_s3;
	logic          neg_s3;
	logic [15:0]   mag_s3;
	logic [31:0]   term_mag;
	logic signed [32:0]      term_s4;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [PRW-1:0]   prod_q;
	logic signed [SHW-1:0]   sh;
	logic signed [EXW-1:0]   ext;
	logic                    fits;
	logic signed [31:0]      sat_val;
	logic                    accept;
	logic                    in_range;

	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign in_range   = (AW + 1)'(partial_index) < (AW + 1)'(NUM_PARTIALS);
	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gain_q <= cfg_data;
		end
	end

	// Partial memories: registered read data; entries read at rd_addr, phases at cnt_q
	assign rd_addr = (state_q == ST_WALK) ? cnt_q : widx_q;

	always_ff @(posedge clk) begin
		par_rd_s1  <= par_mem[rd_addr];
		ph_rd_s1   <= ph_mem[cnt_q];
		par_vld_s1 <= par_vld_q[rd_addr];
		ph_vld_s1  <= ph_vld_q[cnt_q];
		j_s1       <= rd_addr;
		if (par_we) begin
			par_mem[widx_q] <= par_wd;
		end
		if (go_s1) begin
			ph_mem[j_s1] <= ph_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_vld_q <= '0;
			ph_vld_q  <= '0;
		end else begin
			if (par_we) begin
				par_vld_q[widx_q] <= 1'b1;
			end
			if (go_s1) begin
				ph_vld_q[j_s1] <= 1'b1;
			end
		end
	end

	// Entries never written read as their reset contents
	assign amp_s1c = par_vld_s1 ? par_rd_s1.amp : (AMP_ON[j_s1] ? AMP_RESET : 16'd0);
	assign inc_s1c = par_vld_s1 ? par_rd_s1.inc : '0;
	assign ph_s1c  = ph_vld_s1 ? ph_rd_s1 : '0;
	assign ph_next = ph_s1c + inc_s1c;

	assign sq_s1c     = 32'(amp_s1c) * 32'(amp_s1c);
	assign scaled_s1c = PW'(ph_s1c[RW-1:0]) * PW'(SINE_TABLE_DEPTH);

	// Write transaction: merge the new field into the old entry
	assign par_we = (state_q == ST_WR_WB);
	always_comb begin
		par_wd = '{amp: amp_s1c, inc: inc_s1c};
		if (wamp_q) begin
			par_wd.amp = (|wval_q[23:16]) ? 16'hFFFF : wval_q[15:0];
		end else begin
			par_wd.inc = PHASE_BITS'(wval_q);
		end
	end

	always_ff @(posedge clk) begin
		a2_s2   <= sq_s1c[31:16];
		idx_s2  <= scaled_s1c[RW +: SW];
		quad_s2 <= ph_s1c[PHASE_BITS-1 -: 2];
		a2_s3   <= a2_s2;
		neg_s3  <= quad_s2[1];
		term_s4 <= neg_s3 ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag});
	end

	asob_sine_rom #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_sine (
		.clk   (clk),
		.idx   (idx_s2),
		.fold  (quad_s2[0]),
		.mag_s3(mag_s3)
	);

	assign term_mag = 32'(a2_s3) * 32'(mag_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
			go_s2 <= 1'b0;
			go_s3 <= 1'b0;
			go_s4 <= 1'b0;
		end else begin
			go_s1 <= (state_q == ST_WALK);
			go_s2 <= go_s1;
			go_s3 <= go_s2;
			go_s4 <= go_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && kind == KIND_TICK) begin
			acc_q <= '0;
		end else if (go_s4) begin
			acc_q <= acc_q + ACC_W'(term_s4);
		end
		if (state_q == ST_SCALE) begin
			prod_q <= PRW'(acc_q) * PRW'($signed({1'b0, gain_q}));
		end
	end

	// Floor by 2^24, then saturate to the signed 32-bit range
	assign sh      = $signed(prod_q[PRW-1:24]);
	assign ext     = EXW'(sh);
	assign fits    = (&ext[EXW-1:31]) || !(|ext[EXW-1:31]);
	assign sat_val = fits ? ext[31:0] : (ext[EXW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			widx_q      <= '0;
			wval_q      <= '0;
			wamp_q      <= 1'b0;
			out_valid_q <= 1'b0;
			sample_q    <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_SAT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (kind)
							KIND_TICK: begin
								cnt_q   <= '0;
								state_q <= ST_WALK;
							end
							KIND_AMP, KIND_INC: begin
								widx_q <= partial_index;
								wval_q <= write_value;
								wamp_q <= (kind == KIND_AMP);
								if (in_range) begin
									state_q <= ST_WR_RD;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (cnt_q == LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_WR_RD: begin
					state_q <= ST_WR_WB;
				end
				ST_WR_WB: begin
					state_q <= ST_IDLE;
				end
				ST_DRAIN: begin
					if (!(go_s1 || go_s2 || go_s3 || go_s4)) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					// Hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						sample_q    <= sat_val;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(go_s1 || go_s2 || go_s3 || go_s4))
		else $error("item taken while the partial pipeline still holds work");

	a_out_from_sat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_SAT))
		else $error("sample raised outside the saturation step");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (cnt_q <= LAST))
		else $error("partial counter beyond the last partial");

	a_wb_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR_WB) |-> !go_s1)
		else $error("entry write-back overlaps a phase write-back");

endmodule
